[hw/rtl/stl_pkg.sv]
package stl_pkg;

  localparam int OFFSET_WIDTH    = 20;
  localparam int LINE_WIDTH      = 16;
  localparam int KEYWORD_MAX_LEN = 6;
  localparam int KIND_WIDTH      = 6;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_WIDTH      = $clog2(QUEUE_DEPTH);
  localparam int WIDX_WIDTH      = $clog2(KEYWORD_MAX_LEN);

  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX  = '1;
  localparam logic [LINE_WIDTH-1:0]   LINE_MAX = '1;

  localparam logic [KIND_WIDTH-1:0] K_LPAREN   = 6'd0;
  localparam logic [KIND_WIDTH-1:0] K_RPAREN   = 6'd1;
  localparam logic [KIND_WIDTH-1:0] K_LBRACE   = 6'd2;
  localparam logic [KIND_WIDTH-1:0] K_RBRACE   = 6'd3;
  localparam logic [KIND_WIDTH-1:0] K_SEMI     = 6'd4;
  localparam logic [KIND_WIDTH-1:0] K_COMMA    = 6'd5;
  localparam logic [KIND_WIDTH-1:0] K_DOT      = 6'd6;
  localparam logic [KIND_WIDTH-1:0] K_MINUS    = 6'd7;
  localparam logic [KIND_WIDTH-1:0] K_PLUS     = 6'd8;
  localparam logic [KIND_WIDTH-1:0] K_SLASH    = 6'd9;
  localparam logic [KIND_WIDTH-1:0] K_STAR     = 6'd10;
  localparam logic [KIND_WIDTH-1:0] K_BANG     = 6'd11;
  localparam logic [KIND_WIDTH-1:0] K_EQUAL    = 6'd13;
  localparam logic [KIND_WIDTH-1:0] K_LESS     = 6'd15;
  localparam logic [KIND_WIDTH-1:0] K_GREATER  = 6'd17;
  localparam logic [KIND_WIDTH-1:0] K_IDENT    = 6'd19;
  localparam logic [KIND_WIDTH-1:0] K_STRING   = 6'd20;
  localparam logic [KIND_WIDTH-1:0] K_INT      = 6'd21;
  localparam logic [KIND_WIDTH-1:0] K_DOUBLE   = 6'd22;
  localparam logic [KIND_WIDTH-1:0] K_AND      = 6'd23;
  localparam logic [KIND_WIDTH-1:0] K_EOF      = 6'd39;
  localparam logic [KIND_WIDTH-1:0] K_ERR_CHAR = 6'd40;
  localparam logic [KIND_WIDTH-1:0] K_ERR_STR  = 6'd41;

  typedef struct packed {
    logic [KIND_WIDTH-1:0]   kind;
    logic [OFFSET_WIDTH-1:0] start;
    logic [OFFSET_WIDTH-1:0] len;
    logic [LINE_WIDTH-1:0]   line;
  } tok_t;

  // Tokens caused by one source byte, in emission order.
  typedef struct packed {
    logic [1:0]     cnt;
    tok_t [2:0]     tok;
  } bundle_t;

  // Keyword text, first character in the top byte, padded with spaces.
  localparam logic [15:0][47:0] KW_TEXT = '{
    "while ", "var   ", "true  ", "super ", "self  ", "return", "print ", "nil   ",
    "let   ", "if    ", "fun   ", "for   ", "false ", "else  ", "class ", "and   "};
  localparam logic [15:0][2:0] KW_LEN = '{
    3'd5, 3'd3, 3'd4, 3'd5, 3'd4, 3'd6, 3'd5, 3'd3,
    3'd3, 3'd2, 3'd3, 3'd3, 3'd5, 3'd4, 3'd5, 3'd3};

  function automatic logic [OFFSET_WIDTH-1:0] off_inc(input logic [OFFSET_WIDTH-1:0] v);
    off_inc = (v == OFF_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [OFFSET_WIDTH-1:0] off_dec(input logic [OFFSET_WIDTH-1:0] v);
    off_dec = (v == '0) ? v : v - 1'b1;
  endfunction

  function automatic logic [LINE_WIDTH-1:0] line_inc(input logic [LINE_WIDTH-1:0] v);
    line_inc = (v == LINE_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [KIND_WIDTH-1:0] word_kind(
    input logic [KEYWORD_MAX_LEN-1:0][7:0] w,
    input logic [OFFSET_WIDTH-1:0]         len
  );
    logic hit;
    word_kind = K_IDENT;
    for (int i = 0; i < 16; i++) begin
      hit = (len == OFFSET_WIDTH'(KW_LEN[i]));
      for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
        if (j < int'(KW_LEN[i]) && w[j] != KW_TEXT[i][47-8*j -: 8]) hit = 1'b0;
      end
      if (hit) word_kind = K_AND + KIND_WIDTH'(i);
    end
  endfunction

  function automatic logic [KIND_WIDTH-1:0] op_kind(input logic [7:0] c);
    unique case (c)
      "!":     op_kind = K_BANG;
      "=":     op_kind = K_EQUAL;
      "<":     op_kind = K_LESS;
      default: op_kind = K_GREATER;
    endcase
  endfunction

  function automatic logic [KIND_WIDTH-1:0] single_kind(input logic [7:0] c);
    unique case (c)
      "(":     single_kind = K_LPAREN;
      ")":     single_kind = K_RPAREN;
      "{":     single_kind = K_LBRACE;
      "}":     single_kind = K_RBRACE;
      ";":     single_kind = K_SEMI;
      ",":     single_kind = K_COMMA;
      ".":     single_kind = K_DOT;
      "-":     single_kind = K_MINUS;
      "+":     single_kind = K_PLUS;
      "/":     single_kind = K_SLASH;
      "*":     single_kind = K_STAR;
      default: single_kind = K_ERR_CHAR;
    endcase
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c >= "0" && c <= "9";
  endfunction

endpackage

[hw/rtl/source_token_lexer.sv]
// Source token lexer: one source byte (or end mark) per transaction in, tokens out.
// A token reaches the master side through the bundle queue and then the output register.
// Throughput: one byte per cycle while each byte yields at most one token and m_tready
// is high; the output register sends one token per cycle, and a full queue stalls input.
// Reset: synchronous, active high; clears scan state, position to 0 and line to 1.
module source_token_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic [0:0]  s_tuser,   // [0] end_mark
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [5:0] token_kind, [25:6] token_start,
                                 // [45:26] token_length, [61:46] token_line, [63:62] zero
  output logic        m_tlast    // last token caused by one input transaction
);

  logic             full, push, pop, head_valid;
  stl_pkg::bundle_t wr_bundle, head;
  stl_pkg::tok_t    out_tok;

  // Front: scan each byte and bundle the tokens it completes.
  stl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .ch       (s_tdata),
    .end_mark (s_tuser[0]),
    .full     (full),
    .push     (push),
    .bundle   (wr_bundle)
  );

  // Short bundle queue decouples scanning from the token drain.
  stl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_data    (wr_bundle),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: drain one token per cycle into the output register while the output is not stalled.
  stl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_tok    (out_tok),
    .out_last   (m_tlast)
  );

  assign m_tdata = {2'b00, out_tok.line, out_tok.len, out_tok.start, out_tok.kind};

endmodule

[hw/rtl/stl_front.sv]
module stl_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         ch,
  input  logic               end_mark,
  input  logic               full,
  output logic               push,
  output stl_pkg::bundle_t   bundle
);

  typedef enum logic [3:0] {
    M_IDLE, M_OP, M_IDENT, M_INT, M_INT_DOT, M_FRAC, M_STRING
  } mode_t;

  mode_t                                        mode, mode_next;
  logic [7:0]                                   pending, pending_next;
  logic [stl_pkg::KEYWORD_MAX_LEN-1:0][7:0]     word, word_next;
  logic [stl_pkg::OFFSET_WIDTH-1:0]             start, start_next;
  logic [stl_pkg::OFFSET_WIDTH-1:0]             run, run_next;
  logic [stl_pkg::OFFSET_WIDTH-1:0]             pos, pos_next;
  logic [stl_pkg::LINE_WIDTH-1:0]               line, line_next;

  stl_pkg::tok_t pre0, pre1, post;
  logic [1:0]    pre_n;
  logic          post_v, rescan, accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    mode_next    = mode;
    pending_next = pending;
    word_next    = word;
    start_next   = start;
    run_next     = run;
    pos_next     = pos;
    line_next    = line;
    pre0         = '{kind: '0, start: start, len: run, line: line};
    pre1         = '{kind: stl_pkg::K_DOT, start: stl_pkg::off_dec(pos),
                     len: stl_pkg::OFFSET_WIDTH'(1), line: line};
    post         = '{kind: stl_pkg::single_kind(ch), start: pos,
                     len: stl_pkg::OFFSET_WIDTH'(1), line: line};
    pre_n        = 2'd0;
    post_v       = 1'b0;
    rescan       = 1'b0;
    if (end_mark) begin
      unique case (mode)
        M_OP:      begin pre0.kind = stl_pkg::op_kind(pending); pre_n = 2'd1; end
        M_IDENT:   begin pre0.kind = stl_pkg::word_kind(word, run); pre_n = 2'd1; end
        M_INT:     begin pre0.kind = stl_pkg::K_INT; pre_n = 2'd1; end
        M_INT_DOT: begin
          pre0.kind = stl_pkg::K_INT;
          pre0.len  = stl_pkg::off_dec(run);
          pre_n     = 2'd2;
        end
        M_FRAC:    begin pre0.kind = stl_pkg::K_DOUBLE; pre_n = 2'd1; end
        M_STRING:  begin pre0.kind = stl_pkg::K_ERR_STR; pre_n = 2'd1; end
        default:   pre_n = 2'd0;
      endcase
      post         = '{kind: stl_pkg::K_EOF, start: pos, len: '0, line: line};
      post_v       = 1'b1;
      mode_next    = M_IDLE;
      pending_next = '0;
      run_next     = '0;
    end else begin
      unique case (mode)
        M_OP: begin
          pre_n = 2'd1;
          if (ch == "=") begin
            pre0.kind = stl_pkg::op_kind(pending) + 1'b1;
            pre0.len  = stl_pkg::off_inc(run);
          end else begin
            pre0.kind = stl_pkg::op_kind(pending);
            rescan    = 1'b1;
          end
          mode_next    = M_IDLE;
          pending_next = '0;
        end
        M_IDENT: begin
          if (stl_pkg::is_alpha(ch) || stl_pkg::is_digit(ch)) begin
            if (run < stl_pkg::OFFSET_WIDTH'(stl_pkg::KEYWORD_MAX_LEN))
              word_next[run[stl_pkg::WIDX_WIDTH-1:0]] = ch;
            run_next = stl_pkg::off_inc(run);
          end else begin
            pre0.kind = stl_pkg::word_kind(word, run);
            pre_n     = 2'd1;
            mode_next = M_IDLE;
            rescan    = 1'b1;
          end
        end
        M_INT: begin
          if (stl_pkg::is_digit(ch)) begin
            run_next = stl_pkg::off_inc(run);
          end else if (ch == ".") begin
            run_next  = stl_pkg::off_inc(run);
            mode_next = M_INT_DOT;
          end else begin
            pre0.kind = stl_pkg::K_INT;
            pre_n     = 2'd1;
            mode_next = M_IDLE;
            rescan    = 1'b1;
          end
        end
        M_INT_DOT: begin
          if (stl_pkg::is_digit(ch)) begin
            run_next  = stl_pkg::off_inc(run);
            mode_next = M_FRAC;
          end else begin
            pre0.kind = stl_pkg::K_INT;
            pre0.len  = stl_pkg::off_dec(run);
            pre_n     = 2'd2;
            mode_next = M_IDLE;
            rescan    = 1'b1;
          end
        end
        M_FRAC: begin
          if (stl_pkg::is_digit(ch)) begin
            run_next = stl_pkg::off_inc(run);
          end else begin
            pre0.kind = stl_pkg::K_DOUBLE;
            pre_n     = 2'd1;
            mode_next = M_IDLE;
            rescan    = 1'b1;
          end
        end
        M_STRING: begin
          run_next = stl_pkg::off_inc(run);
          if (ch == "\"") begin
            pre0.kind = stl_pkg::K_STRING;
            pre0.len  = stl_pkg::off_inc(run);
            pre_n     = 2'd1;
            mode_next = M_IDLE;
          end else if (ch == "\n") begin
            line_next = stl_pkg::line_inc(line);
          end
        end
        default: begin
          mode_next = M_IDLE;
          rescan    = 1'b1;
        end
      endcase
      if (rescan) begin
        if (ch == " " || ch == "\t" || ch == "\r") begin
          post_v = 1'b0;
        end else if (ch == "\n") begin
          line_next = stl_pkg::line_inc(line);
        end else if (stl_pkg::is_alpha(ch)) begin
          mode_next    = M_IDENT;
          start_next   = pos;
          run_next     = stl_pkg::OFFSET_WIDTH'(1);
          word_next[0] = ch;
        end else if (stl_pkg::is_digit(ch)) begin
          mode_next  = M_INT;
          start_next = pos;
          run_next   = stl_pkg::OFFSET_WIDTH'(1);
        end else if (ch == "\"") begin
          mode_next  = M_STRING;
          start_next = pos;
          run_next   = stl_pkg::OFFSET_WIDTH'(1);
        end else if (ch == "!" || ch == "=" || ch == "<" || ch == ">") begin
          mode_next    = M_OP;
          start_next   = pos;
          run_next     = stl_pkg::OFFSET_WIDTH'(1);
          pending_next = ch;
        end else begin
          post_v = 1'b1;
        end
      end
      pos_next = stl_pkg::off_inc(pos);
    end
  end

  // Pack the flushed tokens first, then the token of the byte itself.
  always_comb begin
    bundle.cnt = pre_n + 2'(post_v);
    bundle.tok = '0;
    case (pre_n)
      2'd0:    bundle.tok[0] = post;
      2'd1:    begin bundle.tok[0] = pre0; bundle.tok[1] = post; end
      default: begin bundle.tok[0] = pre0; bundle.tok[1] = pre1; bundle.tok[2] = post; end
    endcase
  end

  assign push = accept && (bundle.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_IDLE;
      pending <= '0;
      start   <= '0;
      run     <= '0;
      pos     <= '0;
      line    <= stl_pkg::LINE_WIDTH'(1);
    end else if (accept) begin
      mode    <= mode_next;
      pending <= pending_next;
      start   <= start_next;
      run     <= run_next;
      pos     <= pos_next;
      line    <= line_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) word <= word_next;
  end

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    accept && end_mark |=> mode == M_IDLE && run == '0)
    else $error("scanner not idle after end mark");
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line != '0)
    else $error("line count wrapped to zero");
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("bundle pushed into full queue");

endmodule

[hw/rtl/stl_queue.sv]
module stl_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  stl_pkg::bundle_t wr_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output stl_pkg::bundle_t head
);

  stl_pkg::bundle_t [stl_pkg::QUEUE_DEPTH-1:0] mem;
  logic [stl_pkg::QPTR_WIDTH-1:0] wr_ptr, rd_ptr;
  logic [stl_pkg::QPTR_WIDTH:0]   count;

  assign full       = count == (stl_pkg::QPTR_WIDTH+1)'(stl_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (stl_pkg::QPTR_WIDTH+1)'(push) - (stl_pkg::QPTR_WIDTH+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("bundle queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("bundle queue underflow");
  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> head.cnt != 2'd0)
    else $error("empty bundle queued");

endmodule

[hw/rtl/stl_back.sv]
module stl_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  stl_pkg::bundle_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output stl_pkg::tok_t    out_tok,
  output logic             out_last
);

  logic [1:0] idx;
  logic       load, tail;

  assign load = head_valid && (!out_valid || out_ready);
  assign tail = idx == head.cnt - 2'd1;
  assign pop  = load && tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= tail ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok  <= head.tok[idx];
      out_last <= tail;
    end
  end

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx < head.cnt)
    else $error("token index past bundle end");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_tok) && $stable(out_last))
    else $error("output token changed while stalled");
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_last)
    else $error("bundle popped without last token");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  typedef enum logic [2:0] {
    SM_IDLE, SM_OP, SM_WORD, SM_INT, SM_INT_DOT, SM_FRAC, SM_STR
  } scan_mode_t;

  typedef struct packed {
    logic       end_mark;
    logic [7:0] ch;
  } src_item_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [19:0] start;
    logic [19:0] len;
    logic [15:0] line;
    logic        last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;

  source_token_lexer dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  src_item_t  src_queue[$];
  token_t     expected_tokens[$];
  int         error_count = 0;
  bit         hold_source = 1'b0;
  bit         src_taken = 1'b0;
  bit         out_taken = 1'b0;

  // scanner shadow state
  scan_mode_t  sh_mode;
  logic [7:0]  sh_op;
  logic [7:0]  sh_word[6];
  logic [19:0] sh_start, sh_len, sh_pos;
  logic [15:0] sh_line;

  function automatic logic [19:0] off_up(logic [19:0] v);
    return (v == 20'hFFFFF) ? v : v + 20'd1;
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] op_code(logic [7:0] c);
    case (c)
      "!": return stl_pkg::K_BANG;
      "=": return stl_pkg::K_EQUAL;
      "<": return stl_pkg::K_LESS;
      default: return stl_pkg::K_GREATER;
    endcase
  endfunction

  function automatic logic [5:0] punct_code(logic [7:0] c);
    case (c)
      "(": return stl_pkg::K_LPAREN;
      ")": return stl_pkg::K_RPAREN;
      "{": return stl_pkg::K_LBRACE;
      "}": return stl_pkg::K_RBRACE;
      ";": return stl_pkg::K_SEMI;
      ",": return stl_pkg::K_COMMA;
      ".": return stl_pkg::K_DOT;
      "-": return stl_pkg::K_MINUS;
      "+": return stl_pkg::K_PLUS;
      "/": return stl_pkg::K_SLASH;
      "*": return stl_pkg::K_STAR;
      default: return stl_pkg::K_ERR_CHAR;
    endcase
  endfunction

  // keyword lookup only at exact length
  function automatic logic [5:0] word_code();
    string kw[16] = '{"and", "class", "else", "false", "for", "fun", "if", "let",
                      "nil", "print", "return", "self", "super", "true", "var", "while"};
    bit hit;
    for (int i = 0; i < 16; i++) begin
      if (sh_len == 20'(kw[i].len())) begin
        hit = 1'b1;
        for (int j = 0; j < kw[i].len(); j++)
          if (sh_word[j] != kw[i][j]) hit = 1'b0;
        if (hit) return stl_pkg::K_AND + 6'(i);
      end
    end
    return stl_pkg::K_IDENT;
  endfunction

  task automatic push_token(logic [5:0] k, logic [19:0] s, logic [19:0] l, inout int n);
    token_t t;
    t = '{kind: k, start: s, len: l, line: sh_line, last: 1'b0};
    expected_tokens.push_back(t);
    n++;
  endtask

  task automatic scan_fresh(logic [7:0] c, logic [19:0] p, inout int n);
    if (c == " " || c == "\t" || c == "\r") return;
    if (c == "\n") begin
      if (sh_line != 16'hFFFF) sh_line++;
      return;
    end
    if (letter(c) || digit(c) || c == "\"" || c == "!" || c == "=" || c == "<" ||
        c == ">") begin
      sh_start = p;
      sh_len = 20'd1;
      if (letter(c)) begin
        sh_mode = SM_WORD;
        sh_word[0] = c;
      end else if (digit(c)) begin
        sh_mode = SM_INT;
      end else if (c == "\"") begin
        sh_mode = SM_STR;
      end else begin
        sh_mode = SM_OP;
        sh_op = c;
      end
      return;
    end
    push_token(punct_code(c), p, 20'd1, n);
  endtask

  // advance the shadow scanner by one transaction and queue its tokens
  task automatic predict_tokens(src_item_t it);
    int n = 0;
    bit rescan = 1'b0;
    logic [7:0] c = it.ch;
    logic [19:0] p = sh_pos;
    if (it.end_mark) begin
      case (sh_mode)
        SM_OP:   push_token(op_code(sh_op), sh_start, sh_len, n);
        SM_WORD: push_token(word_code(), sh_start, sh_len, n);
        SM_INT:  push_token(stl_pkg::K_INT, sh_start, sh_len, n);
        SM_INT_DOT: begin
          push_token(stl_pkg::K_INT, sh_start, sh_len - 20'd1, n);
          push_token(stl_pkg::K_DOT, sh_pos - 20'(sh_pos != 0), 20'd1, n);
        end
        SM_FRAC: push_token(stl_pkg::K_DOUBLE, sh_start, sh_len, n);
        SM_STR:  push_token(stl_pkg::K_ERR_STR, sh_start, sh_len, n);
        default: ;
      endcase
      push_token(stl_pkg::K_EOF, sh_pos, 20'd0, n);
      sh_mode = SM_IDLE;
      sh_op = '0;
      sh_len = '0;
    end else begin
      case (sh_mode)
        SM_OP: begin
          if (c == "=") begin
            push_token(op_code(sh_op) + 6'd1, sh_start, off_up(sh_len), n);
          end else begin
            push_token(op_code(sh_op), sh_start, sh_len, n);
            rescan = 1'b1;
          end
          sh_mode = SM_IDLE;
          sh_op = '0;
        end
        SM_WORD: begin
          if (letter(c) || digit(c)) begin
            if (sh_len < 20'd6) sh_word[sh_len[2:0]] = c;
            sh_len = off_up(sh_len);
          end else begin
            push_token(word_code(), sh_start, sh_len, n);
            sh_mode = SM_IDLE;
            rescan = 1'b1;
          end
        end
        SM_INT: begin
          if (digit(c) || c == ".") begin
            sh_len = off_up(sh_len);
            if (c == ".") sh_mode = SM_INT_DOT;
          end else begin
            push_token(stl_pkg::K_INT, sh_start, sh_len, n);
            sh_mode = SM_IDLE;
            rescan = 1'b1;
          end
        end
        SM_INT_DOT: begin
          if (digit(c)) begin
            sh_len = off_up(sh_len);
            sh_mode = SM_FRAC;
          end else begin
            push_token(stl_pkg::K_INT, sh_start, sh_len - 20'd1, n);
            push_token(stl_pkg::K_DOT, sh_pos - 20'(sh_pos != 0), 20'd1, n);
            sh_mode = SM_IDLE;
            rescan = 1'b1;
          end
        end
        SM_FRAC: begin
          if (digit(c)) begin
            sh_len = off_up(sh_len);
          end else begin
            push_token(stl_pkg::K_DOUBLE, sh_start, sh_len, n);
            sh_mode = SM_IDLE;
            rescan = 1'b1;
          end
        end
        SM_STR: begin
          sh_len = off_up(sh_len);
          if (c == "\"") begin
            push_token(stl_pkg::K_STRING, sh_start, sh_len, n);
            sh_mode = SM_IDLE;
          end else if (c == "\n" && sh_line != 16'hFFFF) begin
            sh_line++;
          end
        end
        default: rescan = 1'b1;
      endcase
      if (rescan) scan_fresh(c, p, n);
      sh_pos = off_up(sh_pos);
    end
    if (n > 0) expected_tokens[$].last = 1'b1;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // input monitor: predict at the edge where the transaction is accepted
  always @(posedge clk) begin
    src_taken = 1'b0;
    if (!rst && s_tvalid && s_tready) begin
      predict_tokens(src_item_t'({s_tuser[0], s_tdata}));
      src_taken = 1'b1;
    end
  end

  // driver: one transaction per queued byte, random gap before each
  int src_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (src_taken) begin
        src_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      end
      if ((!s_tvalid || src_taken) &&
          (src_gap > 0 || hold_source || src_queue.size() == 0)) begin
        s_tvalid <= 1'b0;
        if (src_gap > 0) src_gap--;
      end else if (!s_tvalid || src_taken) begin
        {s_tuser[0], s_tdata} <= src_queue.pop_front();
        s_tvalid <= 1'b1;
      end
    end
  end

  // sink stall pattern, redrawn per token
  int sink_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) sink_gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 11);
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // monitor: compare each accepted token with the oldest prediction
  always @(posedge clk) begin
    token_t want;
    out_taken = 1'b0;
    if (!rst && m_tvalid && m_tready) begin
      out_taken = 1'b1;
      if (expected_tokens.size() == 0) begin
        report_mismatch("unexpected token kind", m_tdata[5:0], 0);
      end else begin
        want = expected_tokens.pop_front();
        if (m_tdata[5:0] != want.kind) report_mismatch("kind", m_tdata[5:0], want.kind);
        if (m_tdata[25:6] != want.start) report_mismatch("start", m_tdata[25:6], want.start);
        if (m_tdata[45:26] != want.len) report_mismatch("length", m_tdata[45:26], want.len);
        if (m_tdata[61:46] != want.line) report_mismatch("line", m_tdata[61:46], want.line);
        if (m_tdata[63:62] != 2'b00) report_mismatch("pad", m_tdata[63:62], 0);
        if (m_tlast != want.last) report_mismatch("last", m_tlast, want.last);
      end
    end
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) src_queue.push_back('{end_mark: 1'b0, ch: s[i]});
  endtask

  task automatic add_end();
    src_queue.push_back('{end_mark: 1'b1, ch: 8'($urandom_range(0, 255))});
  endtask

  // pick a byte biased toward the lexically interesting ones
  function automatic logic [7:0] pick_byte();
    string alphabet = "aefilnorstuvwhcdpyx_Z09587.\"\n =!<>(){};,-+/*\t\r";
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return alphabet[$urandom_range(0, alphabet.len() - 1)];
  endfunction

  function automatic string pick_lexeme();
    string kw[16] = '{"and", "class", "else", "false", "for", "fun", "if", "let",
                      "nil", "print", "return", "self", "super", "true", "var", "while"};
    string ops[8] = '{"!=", "==", "<=", ">=", "!", "=", "<", ">"};
    case ($urandom_range(0, 7))
      0: return kw[$urandom_range(0, 15)];
      1: return $sformatf("x%0d", $urandom_range(0, 999));
      2: return $sformatf("%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 99));
      3: return $sformatf("%0d", $urandom_range(0, 9999));
      4: return ops[$urandom_range(0, 7)];
      5: return "\"ab c\"";
      6: return kw[$urandom_range(0, 15)].substr(0, 1);
      default: return "";
    endcase
  endfunction

  initial begin
    string s;
    sh_mode = SM_IDLE;
    sh_op = '0;
    sh_start = '0;
    sh_len = '0;
    sh_pos = '0;
    sh_line = 16'd1;
    foreach (sh_word[i]) sh_word[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: operators with and without '=', keywords, int-dot cases, strings
    add_text("!=!<=<>>=== ({};,.-+/*)\n");
    add_text("and x12 while classy if 3.14 7.x 9. \"a\nb\" @");
    src_queue.push_back('{end_mark: 1'b0, ch: 8'hFF});
    add_text("5.");
    add_end();
    add_text("\"open");
    add_end();
    add_end();

    // hold the source until every expected token has drained
    wait (src_queue.size() == 0 && !s_tvalid);
    hold_source = 1'b1;
    wait (expected_tokens.size() == 0);
    repeat (4) @(posedge clk);
    hold_source = 1'b0;

    // random: mostly well-formed lexemes, sprinkled with arbitrary bytes
    while (src_queue.size() < 180) begin
      s = pick_lexeme();
      add_text(s);
      if ($urandom_range(0, 2) == 0) src_queue.push_back('{end_mark: 1'b0, ch: pick_byte()});
      else src_queue.push_back('{end_mark: 1'b0, ch: 8'(" ")});
      if ($urandom_range(0, 30) == 0) add_end();
    end
    add_end();

    wait (src_queue.size() == 0 && !s_tvalid);
    wait (expected_tokens.size() == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_tokens.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/stl_pkg.sv
hw/rtl/stl_front.sv
hw/rtl/stl_queue.sv
hw/rtl/stl_back.sv
hw/rtl/source_token_lexer.sv
tb/tb_top.sv
